FILE: hw/rtl/dead_reckoning_position_update_assert.svh
// assertion helpers for the top-level rtl file
`ifndef DEAD_RECKONING_POSITION_UPDATE_ASSERT_SVH
`define DEAD_RECKONING_POSITION_UPDATE_ASSERT_SVH

// same-cycle implication, checked on every rising edge out of reset
`define DRP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DRP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/drp_pkg.sv
`timescale 1ns / 1ps
package drp_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int POS_WIDTH_DEF    = 40;

    // operand and accumulator widths of the shared serial unit
    localparam int ACC_W = 56;
    localparam int OPA_W = 40;
    localparam int OPB_W = 18;
    localparam int CNT_W = 6;

    // cordic datapath, q30 angles
    localparam int CRD_W = 34;
    localparam logic signed [CRD_W-1:0] CORDIC_K    = 34'sd652032874;
    localparam logic signed [CRD_W-1:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [CRD_W-1:0] HALF_PI_Q30 = 34'sd1686629713;

    localparam logic [OPB_W-1:0] DIV_TICK  = 18'd256000;
    localparam logic [OPB_W-1:0] DIV_LAT   = 18'd2783;
    localparam logic signed [OPB_W-1:0] VEL_SCALE = 18'sd1000;
    localparam logic signed [OPB_W-1:0] LAT_SCALE = 18'sd25;

    localparam logic signed [63:0] LAT_IN_LIMIT = 64'sd20000000000;
    localparam logic signed [ACC_W-1:0] LAT_LIMIT = 56'sd90000000;

    localparam logic [15:0] TICK_RESET = 16'd1000;

    // control from the sequencer to the serial unit
    typedef struct packed {
        logic mul_go;
        logic div_go;
        logic keep;
    } md_cmd_t;

    function automatic logic signed [31:0] atan_q30(input logic [4:0] i);
        logic signed [31:0] r;
        begin
            case (i)
                5'd0:    r = 32'sd843314857;
                5'd1:    r = 32'sd497837830;
                5'd2:    r = 32'sd263043837;
                5'd3:    r = 32'sd133525159;
                5'd4:    r = 32'sd67021687;
                5'd5:    r = 32'sd33543516;
                5'd6:    r = 32'sd16775851;
                5'd7:    r = 32'sd8388438;
                5'd8:    r = 32'sd4194283;
                5'd9:    r = 32'sd2097150;
                5'd10:   r = 32'sd1048576;
                5'd11:   r = 32'sd524288;
                5'd12:   r = 32'sd262144;
                5'd13:   r = 32'sd131072;
                5'd14:   r = 32'sd65536;
                5'd15:   r = 32'sd32768;
                5'd16:   r = 32'sd16384;
                5'd17:   r = 32'sd8192;
                5'd18:   r = 32'sd4096;
                5'd19:   r = 32'sd2048;
                5'd20:   r = 32'sd1024;
                5'd21:   r = 32'sd512;
                5'd22:   r = 32'sd256;
                5'd23:   r = 32'sd128;
                default: r = 32'sd0;
            endcase
            return r;
        end
    endfunction

    // divide by 2^s, round to nearest with halves away from zero
    function automatic logic signed [ACC_W-1:0] rnd_sh(input logic signed [ACC_W-1:0] n,
                                                        input int s);
        logic [ACC_W-1:0] mag;
        logic [ACC_W-1:0] q;
        begin
            mag = n[ACC_W-1] ? ACC_W'(-n) : ACC_W'(n);
            q   = (mag + (ACC_W'(1) << (s - 1))) >> s;
            return n[ACC_W-1] ? -$signed(q) : $signed(q);
        end
    endfunction

endpackage

FILE: hw/rtl/drp_cordic.sv
`timescale 1ns / 1ps
module drp_cordic
    import drp_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [15:0] angle,
    output logic               done,
    output logic signed [15:0] sin_q14,
    output logic signed [15:0] cos_q14
);

    localparam int CW = $clog2(CORDIC_STEPS);

    typedef enum logic [1:0] {C_IDLE, C_RUN, C_FIN} cstate_t;

    cstate_t                 cstate_reg;
    logic signed [CRD_W-1:0] x_reg, y_reg, z_reg;
    logic                    neg_reg;
    logic [CW-1:0]           cnt_reg;
    logic signed [CRD_W-1:0] z0, z_red, xs, ys, at, xf, yf;
    logic                    red_neg;

    always_comb
    begin
        z0 = CRD_W'(angle) <<< 17;
        if (z0 > HALF_PI_Q30)
        begin
            z_red   = z0 - PI_Q30;
            red_neg = 1'b1;
        end
        else if (z0 < -HALF_PI_Q30)
        begin
            z_red   = z0 + PI_Q30;
            red_neg = 1'b1;
        end
        else
        begin
            z_red   = z0;
            red_neg = 1'b0;
        end
        xs = x_reg >>> cnt_reg;
        ys = y_reg >>> cnt_reg;
        at = CRD_W'(atan_q30(5'(cnt_reg)));
        xf = neg_reg ? -x_reg : x_reg;
        yf = neg_reg ? -y_reg : y_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cstate_reg <= C_IDLE;
            done       <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            case (cstate_reg)
                C_IDLE:
                begin
                    if (start)
                    begin
                        x_reg      <= CORDIC_K;
                        y_reg      <= '0;
                        z_reg      <= z_red;
                        neg_reg    <= red_neg;
                        cnt_reg    <= '0;
                        cstate_reg <= C_RUN;
                    end
                end
                C_RUN:
                begin
                    // one micro-rotation per cycle
                    if (!z_reg[CRD_W-1])
                    begin
                        x_reg <= x_reg - ys;
                        y_reg <= y_reg + xs;
                        z_reg <= z_reg - at;
                    end
                    else
                    begin
                        x_reg <= x_reg + ys;
                        y_reg <= y_reg - xs;
                        z_reg <= z_reg + at;
                    end
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CW'(CORDIC_STEPS - 1))
                        cstate_reg <= C_FIN;
                end
                C_FIN:
                begin
                    cos_q14    <= 16'(rnd_sh(ACC_W'(xf), 16));
                    sin_q14    <= 16'(rnd_sh(ACC_W'(yf), 16));
                    done       <= 1'b1;
                    cstate_reg <= C_IDLE;
                end
                default: cstate_reg <= C_IDLE;
            endcase
        end
    end

endmodule

FILE: hw/rtl/drp_muldiv.sv
`timescale 1ns / 1ps
module drp_muldiv
    import drp_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  md_cmd_t                 cmd,
    input  logic signed [OPA_W-1:0] op_a,
    input  logic signed [OPB_W-1:0] op_b,
    input  logic [OPB_W-1:0]        divisor,
    output logic                    done,
    output logic signed [ACC_W-1:0] result
);

    typedef enum logic [1:0] {M_IDLE, M_MUL, M_DIV, M_FIN} mstate_t;

    mstate_t                 mstate_reg;
    logic signed [ACC_W-1:0] acc_reg, mcand_reg;
    logic [OPB_W-1:0]        mplier_reg, dsor_reg, rem_reg;
    logic [ACC_W-1:0]        quo_reg;
    logic                    neg_reg;
    logic [CNT_W-1:0]        cnt_reg;

    logic signed [ACC_W-1:0] addend;
    logic [ACC_W-1:0]        mag;
    logic [OPB_W:0]          rem_t;
    logic                    qbit;
    logic [OPB_W-1:0]        rem_next;

    always_comb
    begin
        addend   = mplier_reg[0] ? mcand_reg : '0;
        mag      = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
        // restoring division, one quotient bit per cycle
        rem_t    = {rem_reg, quo_reg[ACC_W-1]};
        qbit     = rem_t >= {1'b0, dsor_reg};
        rem_next = qbit ? OPB_W'(rem_t - {1'b0, dsor_reg}) : rem_t[OPB_W-1:0];
    end

    assign result = acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mstate_reg <= M_IDLE;
            done       <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            case (mstate_reg)
                M_IDLE:
                begin
                    if (cmd.mul_go)
                    begin
                        mcand_reg  <= ACC_W'(op_a);
                        mplier_reg <= op_b;
                        cnt_reg    <= '0;
                        if (!cmd.keep)
                            acc_reg <= '0;
                        mstate_reg <= M_MUL;
                    end
                    else if (cmd.div_go)
                    begin
                        neg_reg    <= acc_reg[ACC_W-1];
                        quo_reg    <= mag + ACC_W'(divisor >> 1);
                        rem_reg    <= '0;
                        dsor_reg   <= divisor;
                        cnt_reg    <= '0;
                        mstate_reg <= M_DIV;
                    end
                end
                M_MUL:
                begin
                    // multiplier bit serial, sign bit carries negative weight
                    if (cnt_reg == CNT_W'(OPB_W - 1))
                    begin
                        acc_reg    <= acc_reg - addend;
                        done       <= 1'b1;
                        mstate_reg <= M_IDLE;
                    end
                    else
                        acc_reg <= acc_reg + addend;
                    mcand_reg  <= mcand_reg <<< 1;
                    mplier_reg <= mplier_reg >> 1;
                    cnt_reg    <= cnt_reg + 1'b1;
                end
                M_DIV:
                begin
                    quo_reg <= {quo_reg[ACC_W-2:0], qbit};
                    rem_reg <= rem_next;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(ACC_W - 1))
                        mstate_reg <= M_FIN;
                end
                M_FIN:
                begin
                    acc_reg    <= neg_reg ? -$signed(quo_reg) : $signed(quo_reg);
                    done       <= 1'b1;
                    mstate_reg <= M_IDLE;
                end
                default: mstate_reg <= M_IDLE;
            endcase
        end
    end

endmodule

FILE: hw/rtl/dead_reckoning_position_update.sv
`timescale 1ns / 1ps
// dead reckoning position update: one navigation tick in, one position out
// input stream: s_axis_* carries body velocity, acceleration, roll, pitch,
//   yaw and depth; one transfer is one tick
// output stream: m_axis_* carries north and east in mm, depth and latitude
// apb port: register 0 (byte address 0) is tick_ms, the integration interval
// sequence per tick: three cordic runs, then 27 serial multiplies and three
//   serial divides interleaved on the shared bit-serial multiply and divide
//   unit, then the load of the output register, which raises m_axis_tvalid
// throughput: one tick at a time;
//   s_axis_tready is high only while idle
// a finished result sits in the output register, so the next tick is taken
//   while the receiver stalls; a tick that finishes before the previous
//   result is taken waits in its last state
// reset clears the positions to zero and tick_ms to 1000
// write tick_ms only while the block is idle
`include "dead_reckoning_position_update_assert.svh"
module dead_reckoning_position_update
    import drp_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
    parameter int POS_WIDTH    = POS_WIDTH_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    // vel_x, vel_y, vel_z, acc_x, acc_y, acc_z, roll, pitch, yaw, depth_cm
    input  logic [159:0] s_axis_tdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // north_mm, east_mm, depth_out_cm, latitude_udeg, zero fill
    output logic [127:0] m_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int SUM_W = ((POS_WIDTH > OPA_W) ? POS_WIDTH : OPA_W) + 1;
    localparam logic signed [SUM_W-1:0] POS_MAX =
        $signed({{(SUM_W - POS_WIDTH + 1){1'b0}}, {(POS_WIDTH - 1){1'b1}}});
    localparam logic signed [SUM_W-1:0] POS_MIN = -POS_MAX - 1;

    // serial schedule: matrix, body velocity, world velocity, position, latitude
    localparam logic [4:0] ST_T1      = 5'd0;
    localparam logic [4:0] ST_T2      = 5'd1;
    localparam logic [4:0] ST_R00     = 5'd2;
    localparam logic [4:0] ST_R01A    = 5'd3;
    localparam logic [4:0] ST_R01B    = 5'd4;
    localparam logic [4:0] ST_R02A    = 5'd5;
    localparam logic [4:0] ST_R02B    = 5'd6;
    localparam logic [4:0] ST_R10     = 5'd7;
    localparam logic [4:0] ST_R11A    = 5'd8;
    localparam logic [4:0] ST_R11B    = 5'd9;
    localparam logic [4:0] ST_R12A    = 5'd10;
    localparam logic [4:0] ST_R12B    = 5'd11;
    localparam logic [4:0] ST_B0V     = 5'd12;
    localparam logic [4:0] ST_B0A     = 5'd13;
    localparam logic [4:0] ST_B1V     = 5'd14;
    localparam logic [4:0] ST_B1A     = 5'd15;
    localparam logic [4:0] ST_B2V     = 5'd16;
    localparam logic [4:0] ST_B2A     = 5'd17;
    localparam logic [4:0] ST_W0A     = 5'd18;
    localparam logic [4:0] ST_W0B     = 5'd19;
    localparam logic [4:0] ST_W0C     = 5'd20;
    localparam logic [4:0] ST_NSTEP   = 5'd21;
    localparam logic [4:0] ST_W1A     = 5'd22;
    localparam logic [4:0] ST_W1B     = 5'd23;
    localparam logic [4:0] ST_W1C     = 5'd24;
    localparam logic [4:0] ST_ESTEP   = 5'd25;
    localparam logic [4:0] ST_LAT     = 5'd26;
    localparam logic [1:0] ANG_ROLL   = 2'd0;
    localparam logic [1:0] ANG_PITCH  = 2'd1;
    localparam logic [1:0] ANG_YAW    = 2'd2;
    localparam logic       REG_TICK   = 1'b0;

    typedef enum logic [2:0] {
        S_IDLE, S_ROT_GO, S_ROT_WAIT, S_MUL_GO, S_MUL_WAIT, S_DIV_GO, S_DIV_WAIT, S_OUT
    } state_t;

    state_t                      state_reg;
    logic [4:0]                  step_reg;
    logic [1:0]                  ang_reg;
    logic [15:0]                 tick_reg;
    logic signed [15:0]          vx_reg, vy_reg, vz_reg, ax_reg, ay_reg, az_reg;
    logic signed [15:0]          roll_reg, pitch_reg, yaw_reg;
    logic [15:0]                 depth_reg;
    logic signed [15:0]          sr_reg, cr_reg, sp_reg, cp_reg, sy_reg, cy_reg;
    logic signed [OPA_W-1:0]     t1_reg, t2_reg, tmp_reg, b0_reg, b1_reg, b2_reg, w_reg;
    logic signed [OPB_W-1:0]     r00_reg, r01_reg, r02_reg, r10_reg, r11_reg, r12_reg;
    logic signed [POS_WIDTH-1:0] north_reg, east_reg;
    logic signed [27:0]          lat_out;

    logic                    crd_start, crd_done;
    logic signed [15:0]      crd_ang, crd_sin, crd_cos;
    md_cmd_t                 md_cmd;
    logic signed [OPA_W-1:0] op_a;
    logic signed [OPB_W-1:0] op_b;
    logic [OPB_W-1:0]        dsor;
    logic                    md_done;
    logic signed [ACC_W-1:0] md_res;

    logic signed [OPA_W-1:0] r14, r28;
    logic signed [OPB_W-1:0] dt_b;
    logic signed [SUM_W-1:0] pos_sum;
    logic signed [SUM_W-1:0] pos_sat;
    logic signed [63:0]      north_64;
    logic signed [63:0]      east_64;
    logic signed [ACC_W-1:0] lat_q;
    logic signed [27:0]      lat_val;

    // config register
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_TICK) ? {16'd0, tick_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tick_reg <= TICK_RESET;
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_TICK))
            tick_reg <= pwdata[15:0];
    end

    assign s_axis_tready = (state_reg == S_IDLE);

    // shared units
    assign crd_start = (state_reg == S_ROT_GO);

    always_comb
    begin
        case (ang_reg)
            ANG_ROLL:  crd_ang = roll_reg;
            ANG_PITCH: crd_ang = pitch_reg;
            default:   crd_ang = yaw_reg;
        endcase
    end

    drp_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (crd_start),
        .angle   (crd_ang),
        .done    (crd_done),
        .sin_q14 (crd_sin),
        .cos_q14 (crd_cos)
    );

    always_comb
    begin
        dt_b = OPB_W'($signed({1'b0, tick_reg}));
        op_a = '0;
        op_b = '0;
        case (step_reg)
            ST_T1:   begin op_a = OPA_W'(sp_reg); op_b = OPB_W'(sr_reg); end
            ST_T2:   begin op_a = OPA_W'(sp_reg); op_b = OPB_W'(cr_reg); end
            ST_R00:  begin op_a = OPA_W'(cy_reg); op_b = OPB_W'(cp_reg); end
            ST_R01A: begin op_a = t1_reg;         op_b = OPB_W'(cy_reg); end
            ST_R01B: begin op_a = OPA_W'(sy_reg); op_b = OPB_W'(cr_reg); end
            ST_R02A: begin op_a = t2_reg;         op_b = OPB_W'(cy_reg); end
            ST_R02B: begin op_a = OPA_W'(sy_reg); op_b = OPB_W'(sr_reg); end
            ST_R10:  begin op_a = OPA_W'(sy_reg); op_b = OPB_W'(cp_reg); end
            ST_R11A: begin op_a = t1_reg;         op_b = OPB_W'(sy_reg); end
            ST_R11B: begin op_a = OPA_W'(cy_reg); op_b = OPB_W'(cr_reg); end
            ST_R12A: begin op_a = t2_reg;         op_b = OPB_W'(sy_reg); end
            ST_R12B: begin op_a = OPA_W'(cy_reg); op_b = OPB_W'(sr_reg); end
            ST_B0V:  begin op_a = OPA_W'(vx_reg); op_b = VEL_SCALE; end
            ST_B0A:  begin op_a = OPA_W'(ax_reg); op_b = dt_b; end
            ST_B1V:  begin op_a = OPA_W'(vy_reg); op_b = VEL_SCALE; end
            ST_B1A:  begin op_a = OPA_W'(ay_reg); op_b = dt_b; end
            ST_B2V:  begin op_a = OPA_W'(vz_reg); op_b = VEL_SCALE; end
            ST_B2A:  begin op_a = OPA_W'(az_reg); op_b = dt_b; end
            ST_W0A:  begin op_a = b0_reg;         op_b = r00_reg; end
            ST_W0B:  begin op_a = b1_reg;         op_b = r01_reg; end
            ST_W0C:  begin op_a = b2_reg;         op_b = r02_reg; end
            ST_NSTEP: begin op_a = w_reg;         op_b = dt_b; end
            ST_W1A:  begin op_a = b0_reg;         op_b = r10_reg; end
            ST_W1B:  begin op_a = b1_reg;         op_b = r11_reg; end
            ST_W1C:  begin op_a = b2_reg;         op_b = r12_reg; end
            ST_ESTEP: begin op_a = w_reg;         op_b = dt_b; end
            ST_LAT:  begin op_a = north_64[OPA_W-1:0]; op_b = LAT_SCALE; end
            default: begin op_a = '0;             op_b = '0; end
        endcase

        md_cmd.mul_go = (state_reg == S_MUL_GO);
        md_cmd.div_go = (state_reg == S_DIV_GO);
        // second and third terms of a sum add onto the running product
        md_cmd.keep   = (step_reg == ST_B0A) || (step_reg == ST_B1A) ||
                        (step_reg == ST_B2A) || (step_reg == ST_W0B) ||
                        (step_reg == ST_W0C) || (step_reg == ST_W1B) ||
                        (step_reg == ST_W1C);
        dsor          = (step_reg == ST_LAT) ? DIV_LAT : DIV_TICK;
    end

    drp_muldiv u_muldiv (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (md_cmd),
        .op_a    (op_a),
        .op_b    (op_b),
        .divisor (dsor),
        .done    (md_done),
        .result  (md_res)
    );

    // rounding, saturating position add, latitude clamp
    always_comb
    begin
        r14      = OPA_W'(rnd_sh(md_res, 14));
        r28      = OPA_W'(rnd_sh(md_res, 28));
        north_64 = 64'(north_reg);
        east_64  = 64'(east_reg);
        if (step_reg == ST_ESTEP)
            pos_sum = SUM_W'(east_reg) + SUM_W'($signed(md_res[OPA_W-1:0]));
        else
            pos_sum = SUM_W'(north_reg) + SUM_W'($signed(md_res[OPA_W-1:0]));
        if (pos_sum > POS_MAX)
            pos_sat = POS_MAX;
        else if (pos_sum < POS_MIN)
            pos_sat = POS_MIN;
        else
            pos_sat = pos_sum;

        if (md_res > LAT_LIMIT)
            lat_q = LAT_LIMIT;
        else if (md_res < -LAT_LIMIT)
            lat_q = -LAT_LIMIT;
        else
            lat_q = md_res;
        // far north or south: the scaled product would not fit
        if (north_64 > LAT_IN_LIMIT)
            lat_val = 28'(LAT_LIMIT);
        else if (north_64 < -LAT_IN_LIMIT)
            lat_val = 28'(-LAT_LIMIT);
        else
            lat_val = 28'(lat_q);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            m_axis_tvalid <= 1'b0;
            north_reg     <= '0;
            east_reg      <= '0;
            step_reg      <= '0;
            ang_reg       <= '0;
        end
        else
        begin
            // in S_OUT a taken transfer is replaced by the new one below
            if (m_axis_tvalid && m_axis_tready && (state_reg != S_OUT))
                m_axis_tvalid <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        vx_reg    <= s_axis_tdata[15:0];
                        vy_reg    <= s_axis_tdata[31:16];
                        vz_reg    <= s_axis_tdata[47:32];
                        ax_reg    <= s_axis_tdata[63:48];
                        ay_reg    <= s_axis_tdata[79:64];
                        az_reg    <= s_axis_tdata[95:80];
                        roll_reg  <= s_axis_tdata[111:96];
                        pitch_reg <= s_axis_tdata[127:112];
                        yaw_reg   <= s_axis_tdata[143:128];
                        depth_reg <= s_axis_tdata[159:144];
                        ang_reg   <= ANG_ROLL;
                        step_reg  <= ST_T1;
                        state_reg <= S_ROT_GO;
                    end
                end
                S_ROT_GO:
                    state_reg <= S_ROT_WAIT;
                S_ROT_WAIT:
                begin
                    if (crd_done)
                    begin
                        case (ang_reg)
                            ANG_ROLL:  begin sr_reg <= crd_sin; cr_reg <= crd_cos; end
                            ANG_PITCH: begin sp_reg <= crd_sin; cp_reg <= crd_cos; end
                            default:   begin sy_reg <= crd_sin; cy_reg <= crd_cos; end
                        endcase
                        if (ang_reg == ANG_YAW)
                            state_reg <= S_MUL_GO;
                        else
                        begin
                            ang_reg   <= ang_reg + 1'b1;
                            state_reg <= S_ROT_GO;
                        end
                    end
                end
                S_MUL_GO:
                    state_reg <= S_MUL_WAIT;
                S_MUL_WAIT:
                begin
                    if (md_done)
                    begin
                        case (step_reg)
                            ST_T1:   t1_reg  <= OPA_W'(md_res);
                            ST_T2:   t2_reg  <= OPA_W'(md_res);
                            ST_R00:  r00_reg <= OPB_W'(r14);
                            ST_R01A: tmp_reg <= r28;
                            ST_R01B: r01_reg <= OPB_W'(tmp_reg - r14);
                            ST_R02A: tmp_reg <= r28;
                            ST_R02B: r02_reg <= OPB_W'(tmp_reg + r14);
                            ST_R10:  r10_reg <= OPB_W'(r14);
                            ST_R11A: tmp_reg <= r28;
                            ST_R11B: r11_reg <= OPB_W'(tmp_reg + r14);
                            ST_R12A: tmp_reg <= r28;
                            ST_R12B: r12_reg <= OPB_W'(tmp_reg - r14);
                            ST_B0A:  b0_reg  <= OPA_W'(md_res);
                            ST_B1A:  b1_reg  <= OPA_W'(md_res);
                            ST_B2A:  b2_reg  <= OPA_W'(md_res);
                            ST_W0C:  w_reg   <= r14;
                            ST_W1C:  w_reg   <= r14;
                            default: ;
                        endcase
                        if ((step_reg == ST_NSTEP) || (step_reg == ST_ESTEP) ||
                            (step_reg == ST_LAT))
                            state_reg <= S_DIV_GO;
                        else
                        begin
                            step_reg  <= step_reg + 1'b1;
                            state_reg <= S_MUL_GO;
                        end
                    end
                end
                S_DIV_GO:
                    state_reg <= S_DIV_WAIT;
                S_DIV_WAIT:
                begin
                    if (md_done)
                    begin
                        case (step_reg)
                            ST_NSTEP:
                            begin
                                north_reg <= POS_WIDTH'(pos_sat);
                                step_reg  <= ST_W1A;
                                state_reg <= S_MUL_GO;
                            end
                            ST_ESTEP:
                            begin
                                east_reg  <= POS_WIDTH'(pos_sat);
                                step_reg  <= ST_LAT;
                                state_reg <= S_MUL_GO;
                            end
                            default:
                            begin
                                lat_out   <= lat_val;
                                state_reg <= S_OUT;
                            end
                        endcase
                    end
                end
                S_OUT:
                begin
                    // output register free or being emptied this cycle
                    if (!m_axis_tvalid || m_axis_tready)
                    begin
                        m_axis_tdata  <= {4'd0, lat_out, depth_reg,
                                          east_64[OPA_W-1:0], north_64[OPA_W-1:0]};
                        m_axis_tvalid <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `DRP_ASSERT_NXT(a_one_tick_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second tick taken while busy")
    `DRP_ASSERT_IMP(a_lat_in_range, state_reg == S_OUT, (lat_out <= 28'sd90000000) && (lat_out >= -28'sd90000000), "latitude out of range")
    `DRP_ASSERT_IMP(a_step_in_range, state_reg != S_IDLE, step_reg <= ST_LAT, "schedule step past the end")

endmodule
